### rtl/slum_pkg.sv
// Package for the span list union merge block.
// Types, command codes and constants shared by the store, merge and top files.
// No dependencies.
package slum_pkg;

   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_RUN    = 2'd2;

   localparam int RESULT_CAP = 32;

   typedef struct packed {
      logic signed [31:0] start_pos;
      logic signed [31:0] end_pos;
      logic [15:0]        start_tag;
      logic [15:0]        end_tag;
   } slum_span_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MERGE
   } slum_state_type;

   typedef struct packed {
      logic run;
      logic dropped;
   } slum_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } slum_stat_type;

endpackage

### rtl/slum_store.sv
// Span store: one write port, one registered read port.
// Holds one span list. Depends on slum_pkg for the span type.
module slum_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  slum_pkg::slum_span_type wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output slum_pkg::slum_span_type rd_data
);
   import slum_pkg::*;

   slum_span_type span_mem_ff [DEPTH];
   slum_span_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         span_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= span_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/slum_merge.sv
// Merge sequencer: head registers, compare and fuse logic, result register.
// Reads both span stores one entry at a time. Depends on slum_pkg.
module slum_merge #(
   parameter int AW = 4,
   parameter int CW = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  slum_pkg::slum_ctl_type  ctl,
   input  logic [CW-1:0]           a_count,
   input  logic [CW-1:0]           b_count,
   input  slum_pkg::slum_span_type a_rd_data,
   input  slum_pkg::slum_span_type b_rd_data,
   output logic                    a_rd_en,
   output logic [AW-1:0]           a_rd_addr,
   output logic                    b_rd_en,
   output logic [AW-1:0]           b_rd_addr,
   output slum_pkg::slum_stat_type stat,
   output logic                    rsp_strobe,
   output slum_pkg::slum_span_type rsp_span,
   output logic                    rsp_no_span,
   output logic                    rsp_dropped,
   output logic                    rsp_last
);
   import slum_pkg::*;

   localparam int NW = $clog2(RESULT_CAP);

   slum_state_type state_ff, state_in;
   slum_span_type  sa_ff, sa_in, sb_ff, sb_in;
   logic           ha_ff, ha_in, hb_ff, hb_in;
   logic           fa_ff, fb_ff;
   logic [CW-1:0]  ia_ff, ia_in, ib_ff, ib_in;
   logic [NW-1:0]  n_ff, n_in;

   slum_span_type  rsp_span_ff, rsp_span_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_no_span_ff, rsp_no_span_in;
   logic           rsp_dropped_ff, rsp_dropped_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           both_empty;
   logic           emit_a, emit_b, fuse_a, fuse_b, take_a, take_b;
   logic           more_a, more_b;
   logic [CW-1:0]  nia, nib;
   logic           emit_any, emit_last, cap_hit;
   logic           start_run, empty_run;

   // merge decision on the current heads
   always_comb begin
      both_empty = (a_count == '0) && (b_count == '0);
      start_run  = (state_ff == ST_IDLE) && ctl.run;
      empty_run  = start_run && both_empty;
      nia        = CW'(ia_ff + 1'b1);
      nib        = CW'(ib_ff + 1'b1);
      more_a     = nia < a_count;
      more_b     = nib < b_count;
      emit_a     = 1'b0;
      emit_b     = 1'b0;
      fuse_a     = 1'b0;
      fuse_b     = 1'b0;
      if (state_ff == ST_MERGE) begin
         priority if (!hb_ff) begin
            emit_a = ha_ff;
         end else if (!ha_ff) begin
            emit_b = 1'b1;
         end else if ($signed(sa_ff.end_pos) < $signed(sb_ff.start_pos)) begin
            emit_a = 1'b1;
         end else if ($signed(sb_ff.end_pos) < $signed(sa_ff.start_pos)) begin
            emit_b = 1'b1;
         end else if ($signed(sa_ff.start_pos) < $signed(sb_ff.start_pos)) begin
            fuse_a = 1'b1;
         end else begin
            fuse_b = 1'b1;
         end
      end
      take_a   = emit_a || fuse_b;
      take_b   = emit_b || fuse_a;
      emit_any = emit_a || emit_b;
      cap_hit  = n_ff == NW'(RESULT_CAP - 1);
      emit_last = (emit_a && !hb_ff && !more_a) || (emit_b && !ha_ff && !more_b)
                  || (emit_any && cap_hit);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.run && !both_empty) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            priority if (emit_last) begin
               state_in = ST_IDLE;
            end else if ((take_a && more_a) || (take_b && more_b)) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_MERGE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: store reads and status
   always_comb begin
      a_rd_en   = 1'b0;
      a_rd_addr = '0;
      b_rd_en   = 1'b0;
      b_rd_addr = '0;
      stat.busy = state_ff != ST_IDLE;
      stat.done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            a_rd_en   = ctl.run && (a_count != '0);
            b_rd_en   = ctl.run && (b_count != '0);
            stat.done = empty_run;
         end
         ST_FETCH: begin
         end
         ST_MERGE: begin
            a_rd_en   = take_a && more_a && !emit_last;
            a_rd_addr = nia[AW-1:0];
            b_rd_en   = take_b && more_b && !emit_last;
            b_rd_addr = nib[AW-1:0];
            stat.done = emit_last;
         end
         default: begin
         end
      endcase
   end

   // head, index and result datapath
   always_comb begin
      sa_in = sa_ff;
      sb_in = sb_ff;
      ha_in = ha_ff;
      hb_in = hb_ff;
      ia_in = ia_ff;
      ib_in = ib_ff;
      n_in  = n_ff;
      if (start_run) begin
         ha_in = a_count != '0;
         hb_in = b_count != '0;
         ia_in = '0;
         ib_in = '0;
         n_in  = '0;
      end
      if (state_ff == ST_FETCH) begin
         if (fa_ff) begin
            sa_in = a_rd_data;
         end
         if (fb_ff) begin
            sb_in = b_rd_data;
         end
      end
      if (take_a) begin
         ia_in = nia;
         ha_in = more_a;
      end
      if (take_b) begin
         ib_in = nib;
         hb_in = more_b;
      end
      if (fuse_a && ($signed(sa_ff.end_pos) < $signed(sb_ff.end_pos))) begin
         sa_in.end_pos = sb_ff.end_pos;
         sa_in.end_tag = sb_ff.end_tag;
      end
      if (fuse_b && ($signed(sb_ff.end_pos) < $signed(sa_ff.end_pos))) begin
         sb_in.end_pos = sa_ff.end_pos;
         sb_in.end_tag = sa_ff.end_tag;
      end
      if (emit_any) begin
         n_in = NW'(n_ff + 1'b1);
      end

      rsp_valid_in   = emit_any || empty_run;
      rsp_span_in    = emit_a ? sa_ff : sb_ff;
      rsp_no_span_in = 1'b0;
      rsp_dropped_in = ctl.dropped;
      rsp_last_in    = emit_last;
      if (empty_run) begin
         rsp_span_in    = '0;
         rsp_no_span_in = 1'b1;
         rsp_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ha_ff        <= 1'b0;
         hb_ff        <= 1'b0;
         fa_ff        <= 1'b0;
         fb_ff        <= 1'b0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ha_ff        <= ha_in;
         hb_ff        <= hb_in;
         fa_ff        <= a_rd_en;
         fb_ff        <= b_rd_en;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff          <= sa_in;
      sb_ff          <= sb_in;
      ia_ff          <= ia_in;
      ib_ff          <= ib_in;
      rsp_span_ff    <= rsp_span_in;
      rsp_no_span_ff <= rsp_no_span_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_span    = rsp_span_ff;
   assign rsp_no_span = rsp_no_span_ff;
   assign rsp_dropped = rsp_dropped_ff;
   assign rsp_last    = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_fetch_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (fa_ff || fb_ff))
      else $error("fetch state without a pending store read");

   a_merge_has_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (ha_ff || hb_ff))
      else $error("merge step with no head span");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> (rsp_valid_ff && rsp_last_ff))
      else $error("run finished without a last transfer");

   a_no_span_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_no_span_ff) |-> rsp_last_ff)
      else $error("no-span transfer not marked last");
`endif

endmodule

### rtl/span_list_union_merge.sv
// Loads never raise busy. A run with at least one non-empty list raises busy until
// the last result is registered: the list heads are read from the span stores
// through a fetch state, then merge steps follow at one per cycle, with a return
// to the fetch state whenever a step consumes a span and must refill that head
// through the store's registered read port. A run with both lists empty gives
// its single result the cycle after it is taken. Each result is on the rsp_ ports
// for one cycle under rsp_strobe and cannot be held off. Top level; depends on
// slum_pkg, slum_store and slum_merge.
module span_list_union_merge #(
   parameter int SPAN_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_span_start,
   input  logic signed [31:0] req_span_end,
   input  logic [15:0]        req_start_tag,
   input  logic [15:0]        req_end_tag,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_out_start,
   output logic signed [31:0] rsp_out_end,
   output logic [15:0]        rsp_out_start_tag,
   output logic [15:0]        rsp_out_end_tag,
   output logic               rsp_no_span,
   output logic               rsp_dropped,
   output logic               rsp_last
);
   import slum_pkg::*;

   localparam int AW = (SPAN_DEPTH > 1) ? $clog2(SPAN_DEPTH) : 1;
   localparam int CW = $clog2(SPAN_DEPTH + 1);

   logic [CW-1:0]  a_count_ff, a_count_in, b_count_ff, b_count_in;
   logic           overflow_ff, overflow_in;
   logic           accept, a_full, b_full, wr_a, wr_b;
   slum_span_type  wr_span, a_rd_data, b_rd_data, rsp_span;
   slum_ctl_type   ctl;
   slum_stat_type  stat;
   logic           a_rd_en, b_rd_en;
   logic [AW-1:0]  a_rd_addr, b_rd_addr;

   assign accept = start && !stat.busy;
   assign busy   = stat.busy;
   assign a_full = a_count_ff >= CW'(SPAN_DEPTH);
   assign b_full = b_count_ff >= CW'(SPAN_DEPTH);
   assign wr_a   = accept && (req_command == CMD_LOAD_A) && !a_full;
   assign wr_b   = accept && (req_command == CMD_LOAD_B) && !b_full;

   assign wr_span.start_pos = req_span_start;
   assign wr_span.end_pos   = req_span_end;
   assign wr_span.start_tag = req_start_tag;
   assign wr_span.end_tag   = req_end_tag;

   assign ctl.run     = accept && (req_command == CMD_RUN);
   assign ctl.dropped = overflow_ff;

   always_comb begin
      a_count_in  = a_count_ff;
      b_count_in  = b_count_ff;
      overflow_in = overflow_ff;
      priority if (stat.done) begin
         a_count_in  = '0;
         b_count_in  = '0;
         overflow_in = 1'b0;
      end else begin
         if (wr_a) begin
            a_count_in = CW'(a_count_ff + 1'b1);
         end
         if (wr_b) begin
            b_count_in = CW'(b_count_ff + 1'b1);
         end
         if (accept && (((req_command == CMD_LOAD_A) && a_full)
                        || ((req_command == CMD_LOAD_B) && b_full))) begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_count_ff  <= '0;
         b_count_ff  <= '0;
         overflow_ff <= 1'b0;
      end else begin
         a_count_ff  <= a_count_in;
         b_count_ff  <= b_count_in;
         overflow_ff <= overflow_in;
      end
   end

   slum_store #(.DEPTH(SPAN_DEPTH), .AW(AW)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (a_count_ff[AW-1:0]),
      .wr_data (wr_span),
      .rd_en   (a_rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   slum_store #(.DEPTH(SPAN_DEPTH), .AW(AW)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (b_count_ff[AW-1:0]),
      .wr_data (wr_span),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   slum_merge #(.AW(AW), .CW(CW)) u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .a_count     (a_count_ff),
      .b_count     (b_count_ff),
      .a_rd_data   (a_rd_data),
      .b_rd_data   (b_rd_data),
      .a_rd_en     (a_rd_en),
      .a_rd_addr   (a_rd_addr),
      .b_rd_en     (b_rd_en),
      .b_rd_addr   (b_rd_addr),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_span    (rsp_span),
      .rsp_no_span (rsp_no_span),
      .rsp_dropped (rsp_dropped),
      .rsp_last    (rsp_last)
   );

   assign rsp_out_start     = rsp_span.start_pos;
   assign rsp_out_end       = rsp_span.end_pos;
   assign rsp_out_start_tag = rsp_span.start_tag;
   assign rsp_out_end_tag   = rsp_span.end_tag;

endmodule
